FILE: sv/playfair_encryptor_macros.svh
// Assertion macros shared by the Playfair encryptor RTL.
`ifndef PLAYFAIR_ENCRYPTOR_MACROS_SVH
`define PLAYFAIR_ENCRYPTOR_MACROS_SVH

// Plain property, checked on every rising clock edge outside reset.
`define PFE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Same-cycle implication, checked outside reset.
`define PFE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: sv/pfe_pkg.sv
// Types, constants and small helper functions of the Playfair encryptor.
`timescale 1ns / 1ps

package pfe_pkg;

    localparam logic [4:0] NUM_LETTERS = 5'd26;
    localparam logic [4:0] LAST_LETTER = 5'd25;
    localparam logic [4:0] NUM_CELLS   = 5'd25;
    localparam logic [2:0] LAST_IDX    = 3'd4;

    // item kinds
    localparam logic [1:0] KIND_KEY     = 2'd0;
    localparam logic [1:0] KIND_KEY_END = 2'd1;
    localparam logic [1:0] KIND_MSG     = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_FILLER  = 2'd0;
    localparam logic [1:0] CFG_ALT     = 2'd1;
    localparam logic [1:0] CFG_DROPPED = 2'd2;
    localparam logic [1:0] CFG_MERGED  = 2'd3;

    localparam logic [4:0] RST_FILLER  = 5'd23;
    localparam logic [4:0] RST_ALT     = 5'd16;
    localparam logic [4:0] RST_DROPPED = 5'd9;
    localparam logic [4:0] RST_MERGED  = 5'd8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_RD_A,
        ST_RD_B,
        ST_SQ_A,
        ST_OUT_A,
        ST_OUT_B
    } t_state;

    typedef enum logic [1:0] {
        SQ_CALC,
        SQ_NA,
        SQ_NB
    } t_sq_sel;

    typedef struct packed {
        logic    in_ready;
        logic    walk_step;
        logic    pos_sel_a;
        logic    cap_pa;
        logic    calc;
        t_sq_sel sq_sel;
        logic    load_out;
        logic    out_last;
        logic    next_pair;
    } t_cmd;

    typedef struct packed {
        logic is_key_end;
        logic has_pair;
        logic has_second;
        logic walk_done;
        logic out_free;
    } t_status;

    function automatic logic [4:0] f_fold(input logic [4:0] x, input logic [4:0] dropped,
                                          input logic [4:0] merged);
        return (x == dropped) ? merged : x;
    endfunction

    function automatic logic [4:0] f_filler_for(input logic [4:0] x, input logic [4:0] fill,
                                                input logic [4:0] alt);
        return (x == fill) ? alt : fill;
    endfunction

    function automatic logic [2:0] f_row(input logic [4:0] p);
        logic [2:0] r;
        if (p >= 5'd20) begin
            r = 3'd4;
        end else if (p >= 5'd15) begin
            r = 3'd3;
        end else if (p >= 5'd10) begin
            r = 3'd2;
        end else if (p >= 5'd5) begin
            r = 3'd1;
        end else begin
            r = 3'd0;
        end
        return r;
    endfunction

    function automatic logic [2:0] f_col(input logic [4:0] p);
        logic [2:0] row;
        logic [4:0] base;
        row  = f_row(p);
        base = {row, 2'b00} + {2'b00, row};
        return 3'(p - base);
    endfunction

    function automatic logic [4:0] f_cell(input logic [2:0] row, input logic [2:0] col);
        return {row, 2'b00} + {2'b00, row} + {2'b00, col};
    endfunction

    function automatic logic [2:0] f_inc(input logic [2:0] x);
        return (x == LAST_IDX) ? 3'd0 : x + 3'd1;
    endfunction

endpackage

FILE: sv/playfair_encryptor.sv
// Playfair encryptor over letter indices: 5x5 key square built from key items.
// Channels: input items (kind, letter, end_of_message) on i_in_valid/o_in_ready,
// results (cipher_letter, last_of_run) on o_out_valid/i_out_ready, and a
// configuration write channel (index 0 filler, 1 alternate filler, 2 dropped
// letter, 3 merged letter); register values above 25 are stored as 25.
// A key letter or a message letter that closes no pair is taken without leaving idle.
// A key-end item starts the fill, which walks all 26 letters, one per cycle.
// A message letter that closes a pair: the sequencer steps through RD_A, RD_B
// and SQ_A, loads the first result in OUT_A and the second in OUT_B; a second
// pair (end-of-message pad) runs those states again. Each pair costs two position
// reads and two square reads through the single read port of each memory.
// The last result of a transaction carries last_of_run.
// A one-entry output register holds a result while the receiver stalls; the
// sequencer waits on it, and a new transaction is taken once the last result
// of the previous one is loaded there.
// Reset (synchronous, active low) empties the square, the pending letter and
// the output register, and restores the configuration defaults (x, q, j, i).
`timescale 1ns / 1ps
`include "playfair_encryptor_macros.svh"

module playfair_encryptor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_kind,
    input  logic [4:0] i_letter,
    input  logic       i_end_of_message,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [4:0] o_cipher_letter,
    output logic       o_last_of_run,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [4:0] i_cfg_data
);
    import pfe_pkg::*;

    t_cmd    w_cmd;
    t_status w_sts;

    pfe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    pfe_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_kind           (i_kind),
        .i_letter         (i_letter),
        .i_end_of_message (i_end_of_message),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_cipher_letter  (o_cipher_letter),
        .o_last_of_run    (o_last_of_run),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts)
    );

    assign o_in_ready  = w_cmd.in_ready;
    assign o_cfg_ready = 1'b1;

    `PFE_ASSERT_IMP(a_load_needs_slot, w_cmd.load_out, w_sts.out_free, "load over waiting result")
    `PFE_ASSERT_IMP(a_second_pair_busy, w_sts.has_second, !o_in_ready, "input while pair queued")
    `PFE_ASSERT(a_valid_from_load, $rose(o_out_valid) |-> $past(w_cmd.load_out), "unloaded valid")

endmodule

FILE: sv/pfe_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pfe_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 25
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/pfe_ctrl.sv
// Sequencing state machine of the Playfair encryptor.
`timescale 1ns / 1ps

module pfe_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  pfe_pkg::t_status i_sts,
    output pfe_pkg::t_cmd    o_cmd
);
    import pfe_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_sts.is_key_end) begin
                        n_state = ST_FILL;
                    end else if (i_sts.has_pair) begin
                        n_state = ST_RD_A;
                    end
                end
            end
            ST_FILL: begin
                if (i_sts.walk_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_RD_A: n_state = ST_RD_B;
            ST_RD_B: n_state = ST_SQ_A;
            ST_SQ_A: n_state = ST_OUT_A;
            ST_OUT_A: begin
                if (i_sts.out_free) begin
                    n_state = ST_OUT_B;
                end
            end
            ST_OUT_B: begin
                if (i_sts.out_free) begin
                    n_state = i_sts.has_second ? ST_RD_A : ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.sq_sel = SQ_NB;
        case (r_state)
            ST_IDLE: o_cmd.in_ready = 1'b1;
            ST_FILL: o_cmd.walk_step = 1'b1;
            ST_RD_A: o_cmd.pos_sel_a = 1'b1;
            ST_RD_B: o_cmd.cap_pa = 1'b1;
            ST_SQ_A: begin
                o_cmd.calc   = 1'b1;
                o_cmd.sq_sel = SQ_CALC;
            end
            ST_OUT_A: begin
                // move the read on to the second cell once the first is taken
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.sq_sel   = SQ_NB;
                end else begin
                    o_cmd.sq_sel = SQ_NA;
                end
            end
            ST_OUT_B: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out  = 1'b1;
                    o_cmd.out_last  = !i_sts.has_second;
                    o_cmd.next_pair = i_sts.has_second;
                end
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

FILE: sv/pfe_datapath.sv
// Datapath: config registers, key square, pair logic and output register.
`timescale 1ns / 1ps

module pfe_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [1:0]       i_kind,
    input  logic [4:0]       i_letter,
    input  logic             i_end_of_message,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic [4:0]       o_cipher_letter,
    output logic             o_last_of_run,
    input  logic             i_cfg_valid,
    input  logic [1:0]       i_cfg_index,
    input  logic [4:0]       i_cfg_data,
    input  pfe_pkg::t_cmd    i_cmd,
    output pfe_pkg::t_status o_sts
);
    import pfe_pkg::*;

    // configuration
    logic [4:0] r_filler, r_alt, r_dropped, r_merged;
    logic [4:0] w_cfg_val;

    // square bookkeeping
    logic [NUM_LETTERS-1:0] r_used;
    logic [4:0] r_fill;
    logic [4:0] r_walk;
    logic       w_place_req, w_place_do;
    logic [4:0] w_place_letter;

    // message pairing
    logic       r_pv;
    logic [4:0] r_pend;
    logic [4:0] r_a, r_b, r_a2;
    logic       r_has2;
    logic       w_accept, w_ok, w_pair_x, w_pair_y, w_pv1;
    logic [4:0] w_lf, w_p1, w_xb, w_fill_f, w_fill_alt;

    // cell lookup
    logic [4:0] w_pos_rd, w_sq_rd, w_pos_raddr, w_sq_raddr;
    logic [4:0] r_ca, r_na, r_nb, w_pb, w_na, w_nb;
    logic [2:0] w_ra, w_ca, w_rb, w_cb;

    // output register
    logic       r_out_valid, n_out_valid;
    logic [4:0] r_cipher;
    logic       r_last;

    assign w_accept   = i_in_valid & i_cmd.in_ready;
    assign w_ok       = (i_letter < NUM_LETTERS);
    assign w_lf       = f_fold(i_letter, r_dropped, r_merged);
    assign w_fill_f   = f_fold(r_filler, r_dropped, r_merged);
    assign w_fill_alt = f_fold(r_alt, r_dropped, r_merged);
    assign w_cfg_val  = (i_cfg_data > LAST_LETTER) ? LAST_LETTER : i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filler  <= RST_FILLER;
            r_alt     <= RST_ALT;
            r_dropped <= RST_DROPPED;
            r_merged  <= RST_MERGED;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FILLER:  r_filler  <= w_cfg_val;
                CFG_ALT:     r_alt     <= w_cfg_val;
                CFG_DROPPED: r_dropped <= w_cfg_val;
                CFG_MERGED:  r_merged  <= w_cfg_val;
                default:     r_filler  <= r_filler;
            endcase
        end
    end

    // placing a letter: key letter on acceptance, or one step of the key-end walk
    assign w_place_letter = i_cmd.walk_step ? r_walk : w_lf;
    assign w_place_req    = (i_cmd.walk_step & (r_walk != r_dropped))
                          | (w_accept & (i_kind == KIND_KEY) & w_ok);
    assign w_place_do     = w_place_req & (r_fill < NUM_CELLS) & !r_used[w_place_letter];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_fill <= '0;
        end else if (w_place_do) begin
            r_used[w_place_letter] <= 1'b1;
            r_fill <= r_fill + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && (i_kind == KIND_KEY_END)) begin
            r_walk <= '0;
        end else if (i_cmd.walk_step) begin
            r_walk <= r_walk + 5'd1;
        end
    end

    // pair planning: first the pair closed by this letter, then the end-of-message pad
    assign w_pair_x = w_ok & r_pv;
    assign w_pv1    = w_ok ? (!r_pv | (r_pend == w_lf)) : r_pv;
    assign w_p1     = (w_ok && !(r_pv && (r_pend != w_lf))) ? w_lf : r_pend;
    assign w_pair_y = i_end_of_message & w_pv1;
    assign w_xb     = (r_pend == w_lf) ? f_filler_for(r_pend, w_fill_f, w_fill_alt) : w_lf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv   <= 1'b0;
            r_pend <= '0;
            r_has2 <= 1'b0;
        end else if (w_accept && (i_kind == KIND_MSG)) begin
            r_pv   <= w_pv1 & !i_end_of_message;
            r_pend <= w_p1;
            r_has2 <= w_pair_x & w_pair_y;
        end else if (i_cmd.next_pair) begin
            r_has2 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && (i_kind == KIND_MSG)) begin
            r_a2 <= w_p1;
            if (w_pair_x) begin
                r_a <= r_pend;
                r_b <= w_xb;
            end else begin
                r_a <= w_p1;
                r_b <= f_filler_for(w_p1, w_fill_f, w_fill_alt);
            end
        end else if (i_cmd.next_pair) begin
            r_a <= r_a2;
            r_b <= f_filler_for(r_a2, w_fill_f, w_fill_alt);
        end
    end

    // cell positions: a letter never placed reads as cell 0
    assign w_pos_raddr = i_cmd.pos_sel_a ? r_a : r_b;
    assign w_pb        = r_used[r_b] ? w_pos_rd : 5'd0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_pa) begin
            r_ca <= r_used[r_a] ? w_pos_rd : 5'd0;
        end
    end

    always_comb begin
        w_ra = f_row(r_ca);
        w_ca = f_col(r_ca);
        w_rb = f_row(w_pb);
        w_cb = f_col(w_pb);
        if (w_ra == w_rb) begin
            w_na = f_cell(w_ra, f_inc(w_ca));
            w_nb = f_cell(w_rb, f_inc(w_cb));
        end else if (w_ca == w_cb) begin
            w_na = f_cell(f_inc(w_ra), w_ca);
            w_nb = f_cell(f_inc(w_rb), w_cb);
        end else begin
            w_na = f_cell(w_ra, w_cb);
            w_nb = f_cell(w_rb, w_ca);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_na <= w_na;
            r_nb <= w_nb;
        end
    end

    always_comb begin
        case (i_cmd.sq_sel)
            SQ_CALC: w_sq_raddr = w_na;
            SQ_NA:   w_sq_raddr = r_na;
            SQ_NB:   w_sq_raddr = r_nb;
            default: w_sq_raddr = r_nb;
        endcase
    end

    pfe_ram #(
        .WIDTH (5),
        .DEPTH (25)
    ) u_square (
        .i_clk   (i_clk),
        .i_we    (w_place_do),
        .i_waddr (r_fill),
        .i_wdata (w_place_letter),
        .i_raddr (w_sq_raddr),
        .o_rdata (w_sq_rd)
    );

    pfe_ram #(
        .WIDTH (5),
        .DEPTH (26)
    ) u_position (
        .i_clk   (i_clk),
        .i_we    (w_place_do),
        .i_waddr (w_place_letter),
        .i_wdata (r_fill),
        .i_raddr (w_pos_raddr),
        .o_rdata (w_pos_rd)
    );

    // output register
    always_comb begin
        if (i_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_cipher <= w_sq_rd;
            r_last   <= i_cmd.out_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_cipher_letter = r_cipher;
    assign o_last_of_run   = r_last;

    assign o_sts.is_key_end = (i_kind == KIND_KEY_END);
    assign o_sts.has_pair   = (i_kind == KIND_MSG) & (w_pair_x | w_pair_y);
    assign o_sts.has_second = r_has2;
    assign o_sts.walk_done  = (r_walk == LAST_LETTER);
    assign o_sts.out_free   = !r_out_valid | i_out_ready;

endmodule
